// File: rtl/core/lspe_pkg.sv
// shared types and constants of the lsb stego payload extractor
// used by lspe_front, lspe_back and the top level; no dependencies
`default_nettype none

package lspe_pkg;

  localparam int unsigned MaxMagicBytesDefault = 8;
  localparam int unsigned CarrierWidth         = 8;
  localparam int unsigned SizeWidth            = 32;
  localparam int unsigned OutByteWidth         = 8;
  localparam int unsigned CfgAddrWidth         = 2;
  localparam int unsigned CfgDataWidth         = 64;

  localparam logic [7:0]  HeaderLengthReset = 8'd54;
  localparam logic [3:0]  MagicLengthReset  = 4'd2;
  localparam logic [63:0] MagicWordReset    = 64'd10787;

  // configuration register indexes
  localparam logic [CfgAddrWidth-1:0] CfgHeaderLength = 2'd0;
  localparam logic [CfgAddrWidth-1:0] CfgMagicLength  = 2'd1;
  localparam logic [CfgAddrWidth-1:0] CfgMagicWord    = 2'd2;

  typedef enum logic [2:0] {
    KIND_EXT_BYTE = 3'd0,
    KIND_PAY_BYTE = 3'd1,
    KIND_EXT_SIZE = 3'd2,
    KIND_PAY_SIZE = 3'd3,
    KIND_MAGIC_ERR = 3'd4
  } lspe_kind_e;

  // one decoded result as it travels through the queue
  typedef struct packed {
    lspe_kind_e            kind;
    logic [SizeWidth-1:0]  value;  // decoded byte in low bits, or a length
    logic                  last;
  } lspe_item_t;

  // push request from the front to the back
  typedef struct packed {
    logic       valid;
    lspe_item_t item;
  } lspe_push_t;

endpackage

`default_nettype wire

// File: rtl/core/lspe_front.sv
// front part: configuration registers, header skip, bit collection and field parse
// depends on lspe_pkg; produces at most one result per accepted carrier byte
`default_nettype none

module lspe_front
  import lspe_pkg::*;
#(
  parameter int unsigned MAX_MAGIC_BYTES = MaxMagicBytesDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgAddrWidth-1:0] cfg_addr_i,
  input  wire logic [CfgDataWidth-1:0] cfg_wdata_i,
  input  wire logic                    accept_i,
  input  wire logic [CarrierWidth-1:0] carrier_i,
  input  wire logic                    sof_i,
  output lspe_push_t                   push_o
);

  localparam int unsigned MagicIdxWidth = (MAX_MAGIC_BYTES > 1) ? $clog2(MAX_MAGIC_BYTES) : 1;
  localparam logic [3:0]  MagicMax      = 4'(MAX_MAGIC_BYTES);

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_MAGIC    = 3'd1,
    PH_EXT_SIZE = 3'd2,
    PH_EXT      = 3'd3,
    PH_PAY_SIZE = 3'd4,
    PH_PAYLOAD  = 3'd5,
    PH_DONE     = 3'd6,
    PH_HALT     = 3'd7
  } phase_e;

  logic [7:0]               header_length_q;
  logic [3:0]               magic_length_q;
  logic [63:0]              magic_word_q;

  phase_e                   phase_q, phase_d;
  logic [7:0]               header_cnt_q, header_cnt_d;
  logic [4:0]               bit_pos_q, bit_pos_d;
  logic [31:0]              asm_q, asm_d;
  logic [31:0]              remain_q, remain_d;
  logic [MagicIdxWidth-1:0] magic_idx_q, magic_idx_d;
  logic                     magic_diff_q, magic_diff_d;

  // state as seen by the current byte, after a possible restart
  phase_e                   ph;
  logic [7:0]               hc;
  logic [4:0]               bp;
  logic [31:0]              aw;
  logic [31:0]              rc;
  logic [MagicIdxWidth-1:0] mi;
  logic                     md;

  logic [31:0]              asm_new;
  logic [4:0]               bp_new;
  logic                     word_done;
  logic [3:0]               magic_cnt;
  logic [3:0]               magic_next;
  logic [7:0]               magic_expect;
  logic [31:0]              remain_dec;
  logic                     diff_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_length_q <= HeaderLengthReset;
      magic_length_q  <= MagicLengthReset;
      magic_word_q    <= MagicWordReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgHeaderLength: header_length_q <= cfg_wdata_i[7:0];
        CfgMagicLength:  magic_length_q  <= cfg_wdata_i[3:0];
        CfgMagicWord:    magic_word_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (magic_length_q == 4'd0) begin
      magic_cnt = 4'd1;
    end else if (magic_length_q > MagicMax) begin
      magic_cnt = MagicMax;
    end else begin
      magic_cnt = magic_length_q;
    end
  end

  always_comb begin
    ph = sof_i ? PH_HEADER : phase_q;
    hc = sof_i ? 8'd0 : header_cnt_q;
    bp = sof_i ? 5'd0 : bit_pos_q;
    aw = sof_i ? 32'd0 : asm_q;
    rc = sof_i ? 32'd0 : remain_q;
    mi = sof_i ? '0 : magic_idx_q;
    md = sof_i ? 1'b0 : magic_diff_q;

    if (ph == PH_HEADER && hc >= header_length_q) begin
      ph = PH_MAGIC;
    end

    asm_new      = aw | (32'(carrier_i[0]) << bp);
    bp_new       = bp + 5'd1;
    word_done    = (ph == PH_EXT_SIZE || ph == PH_PAY_SIZE) ? (bp_new == 5'd0)
                                                            : (bp_new == 5'd8);
    magic_next   = 4'(mi) + 4'd1;
    magic_expect = 8'(magic_word_q >> {3'(mi), 3'b000});
    remain_dec   = rc - 32'd1;
    diff_new     = md | (asm_new[7:0] != magic_expect);

    phase_d      = phase_q;
    header_cnt_d = header_cnt_q;
    bit_pos_d    = bit_pos_q;
    asm_d        = asm_q;
    remain_d     = remain_q;
    magic_idx_d  = magic_idx_q;
    magic_diff_d = magic_diff_q;

    push_o.valid      = 1'b0;
    push_o.item.kind  = KIND_EXT_BYTE;
    push_o.item.value = 32'd0;
    push_o.item.last  = 1'b0;

    if (accept_i) begin
      // restart values become the state, even when the byte does nothing else
      phase_d      = ph;
      header_cnt_d = hc;
      bit_pos_d    = bp;
      asm_d        = aw;
      remain_d     = rc;
      magic_idx_d  = mi;
      magic_diff_d = md;

      case (ph)
        PH_DONE, PH_HALT: ;
        PH_HEADER: begin
          header_cnt_d = hc + 8'd1;
        end
        default: begin
          if (!word_done) begin
            asm_d     = asm_new;
            bit_pos_d = bp_new;
          end else begin
            asm_d     = 32'd0;
            bit_pos_d = 5'd0;
            case (ph)
              PH_MAGIC: begin
                magic_diff_d = diff_new;
                if (magic_next >= magic_cnt) begin
                  magic_idx_d = '0;
                  if (diff_new) begin
                    phase_d          = PH_HALT;
                    push_o.valid     = 1'b1;
                    push_o.item.kind = KIND_MAGIC_ERR;
                  end else begin
                    phase_d = PH_EXT_SIZE;
                  end
                end else begin
                  magic_idx_d = MagicIdxWidth'(magic_next);
                end
              end
              PH_EXT_SIZE: begin
                remain_d          = asm_new;
                phase_d           = (asm_new == 32'd0) ? PH_PAY_SIZE : PH_EXT;
                push_o.valid      = 1'b1;
                push_o.item.kind  = KIND_EXT_SIZE;
                push_o.item.value = asm_new;
              end
              PH_EXT: begin
                remain_d          = remain_dec;
                push_o.valid      = 1'b1;
                push_o.item.kind  = KIND_EXT_BYTE;
                push_o.item.value = {24'd0, asm_new[7:0]};
                if (remain_dec == 32'd0) begin
                  phase_d          = PH_PAY_SIZE;
                  push_o.item.last = 1'b1;
                end
              end
              PH_PAY_SIZE: begin
                remain_d          = asm_new;
                phase_d           = (asm_new == 32'd0) ? PH_DONE : PH_PAYLOAD;
                push_o.valid      = 1'b1;
                push_o.item.kind  = KIND_PAY_SIZE;
                push_o.item.value = asm_new;
              end
              PH_PAYLOAD: begin
                remain_d          = remain_dec;
                push_o.valid      = 1'b1;
                push_o.item.kind  = KIND_PAY_BYTE;
                push_o.item.value = {24'd0, asm_new[7:0]};
                if (remain_dec == 32'd0) begin
                  phase_d          = PH_DONE;
                  push_o.item.last = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      header_cnt_q <= 8'd0;
      bit_pos_q    <= 5'd0;
      asm_q        <= 32'd0;
      remain_q     <= 32'd0;
      magic_idx_q  <= '0;
      magic_diff_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      header_cnt_q <= header_cnt_d;
      bit_pos_q    <= bit_pos_d;
      asm_q        <= asm_d;
      remain_q     <= remain_d;
      magic_idx_q  <= magic_idx_d;
      magic_diff_q <= magic_diff_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lspe_back.sv
// back part: two-entry result queue and output formatting
// depends on lspe_pkg; drives the output stream straight from queue registers
`default_nettype none

module lspe_back
  import lspe_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  lspe_push_t                   push_i,
  output logic                         ready_o,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output lspe_kind_e                   out_kind_o,
  output logic [OutByteWidth-1:0]      out_byte_o,
  output logic [SizeWidth-1:0]         out_size_o,
  output logic                         out_last_o
);

  lspe_item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;
  lspe_item_t head;

  assign ready_o     = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign do_push     = push_i.valid;
  assign do_pop      = out_valid_o && out_ready_i;
  assign head        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  // unused fields read as zero
  always_comb begin
    out_kind_o = head.kind;
    out_last_o = head.last;
    out_byte_o = 8'd0;
    out_size_o = 32'd0;
    case (head.kind)
      KIND_EXT_BYTE, KIND_PAY_BYTE: out_byte_o = head.value[7:0];
      KIND_EXT_SIZE, KIND_PAY_SIZE: out_size_o = head.value;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/lsb_stego_payload_extractor_core.sv
// top level of the lsb stego payload extractor
// depends on lspe_pkg, lspe_front and lspe_back
//
// usage:
// - input stream s_axis: one carrier file byte per transaction, tuser marks the
//   first byte of a new image and restarts the parse at that byte
// - output stream m_axis: one decoded item per transaction; tuser carries the
//   kind (extension byte, payload byte, extension size, payload size, magic
//   mismatch), tlast marks the final extension byte and final payload byte
// - cfg port: header length, magic length and magic word, written while idle
// - throughput: one carrier byte per cycle while the queue has a free entry; each
//   result is written into a queue register before it appears on m_axis
// - the front parses each byte in the accepting cycle and pushes its result
//   into a two-entry queue in the back, which drives m_axis from registers
// - when the receiver stalls, the queue fills and s_axis_tready drops once both
//   entries are taken; it rises again the cycle after a result leaves
// - reset restores the register defaults (header 54, magic length 2, magic
//   word 0x2A23), empties the queue and starts a fresh parse as if a start
//   mark had been seen
`default_nettype none

module lsb_stego_payload_extractor_core
  import lspe_pkg::*;
#(
  parameter int unsigned MAX_MAGIC_BYTES = MaxMagicBytesDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // configuration write port
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgAddrWidth-1:0] cfg_addr_i,
  input  wire logic [CfgDataWidth-1:0] cfg_wdata_i,
  // carrier byte stream
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [7:0]              s_axis_tdata,   // [7:0] carrier_byte
  input  wire logic [0:0]              s_axis_tuser,   // [0] start_of_file
  // decoded item stream
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [39:0]                  m_axis_tdata,   // [7:0] out_byte, [39:8] size_value
  output logic [2:0]                   m_axis_tuser,   // [2:0] kind
  output logic                         m_axis_tlast    // last
);

  lspe_push_t              push;
  logic                    back_ready;
  logic                    in_accept;
  lspe_kind_e              out_kind;
  logic [OutByteWidth-1:0] out_byte;
  logic [SizeWidth-1:0]    out_size;

  assign s_axis_tready = back_ready;
  assign in_accept     = s_axis_tvalid && back_ready;

  // front: register file, header skip, lsb collection, field parse
  lspe_front #(
    .MAX_MAGIC_BYTES(MAX_MAGIC_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (in_accept),
    .carrier_i  (s_axis_tdata),
    .sof_i      (s_axis_tuser[0]),
    .push_o     (push)
  );

  // back: result queue and output formatting
  lspe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .ready_o    (back_ready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_kind_o (out_kind),
    .out_byte_o (out_byte),
    .out_size_o (out_size),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {out_size, out_byte};
  assign m_axis_tuser = out_kind;

endmodule

`default_nettype wire
